[rtl/core/pst_pkg.sv]
package pst_pkg;

	localparam int SLOTS = 8;
	localparam int SLOT_W = 3;
	localparam int CNT_W = 4;
	localparam int Q_DEPTH = 2;

	localparam logic [1:0] MODE_PKT  = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_LOOK = 2'd2;
	localparam logic [1:0] MODE_RSVD = 2'd3;

	localparam logic [1:0] CFG_EMA_WEIGHT = 2'd0;
	localparam logic [1:0] CFG_TIMEOUT    = 2'd1;
	localparam logic [1:0] CFG_STATS_LIM  = 2'd2;

	localparam logic [15:0] STALE_LIMIT = 16'h8000;
	localparam logic [8:0]  WEIGHT_ONE  = 9'd256;

	typedef struct packed {
		logic [1:0]        mode;
		logic [31:0]       peer_id;
		logic [47:0]       mac_addr;
		logic [15:0]       seq_num;
		logic signed [7:0] rssi_sample;
		logic [31:0]       now_ms;
	} in_t;

	typedef struct packed {
		logic               fresh;
		logic               found;
		logic               table_full;
		logic               is_online;
		logic [15:0]        last_seq_out;
		logic [15:0]        received_count;
		logic [15:0]        missed_count;
		logic signed [7:0]  raw_rssi;
		logic signed [15:0] smooth_rssi;
		logic [31:0]        last_seen;
		logic [47:0]        peer_mac;
	} out_t;

	typedef struct packed {
		logic [8:0]  ema_weight;
		logic [31:0] offline_timeout;
		logic [15:0] stats_limit;
	} cfg_t;

	typedef struct packed {
		logic is_pkt;
		logic is_tick;
		logic is_look;
	} cls_t;

	typedef struct packed {
		in_t  item;
		cls_t cls;
	} job_t;

endpackage

[rtl/core/pst_front.sv]
module pst_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pst_pkg::in_t  cmd,
	input  logic          pop,
	output logic          empty,
	output pst_pkg::job_t head
);

	pst_pkg::job_t q_mem [pst_pkg::Q_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	pst_pkg::job_t job_in;

	always_comb begin
		job_in.item = cmd;
		job_in.cls.is_pkt = (cmd.mode == pst_pkg::MODE_PKT);
		job_in.cls.is_tick = (cmd.mode == pst_pkg::MODE_TICK);
		job_in.cls.is_look = (cmd.mode == pst_pkg::MODE_LOOK);
	end

	assign busy = (fill_q == 2'(pst_pkg::Q_DEPTH));
	assign empty = (fill_q == 2'd0);
	assign push = start && !busy;
	assign head = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

endmodule

[rtl/core/pst_back.sv]
module pst_back (
	input  logic          clk,
	input  logic          arst_n,
	input  pst_pkg::cfg_t cfg,
	input  logic          empty,
	input  pst_pkg::job_t head,
	output logic          pop,
	output logic          done,
	output pst_pkg::out_t result
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOOK  = 3'd1;
	localparam logic [2:0] ST_CALC  = 3'd2;
	localparam logic [2:0] ST_WRITE = 3'd3;
	localparam logic [2:0] ST_TICK  = 3'd4;

	logic [31:0]        id_mem     [pst_pkg::SLOTS];
	logic [47:0]        mac_mem    [pst_pkg::SLOTS];
	logic [15:0]        seq_mem    [pst_pkg::SLOTS];
	logic [15:0]        rcv_mem    [pst_pkg::SLOTS];
	logic [15:0]        mis_mem    [pst_pkg::SLOTS];
	logic signed [7:0]  raw_mem    [pst_pkg::SLOTS];
	logic signed [15:0] smooth_mem [pst_pkg::SLOTS];
	logic [31:0]        seen_mem   [pst_pkg::SLOTS];
	logic               online_mem [pst_pkg::SLOTS];

	logic [2:0]                  state_q;
	pst_pkg::job_t               job_q;
	logic [pst_pkg::CNT_W-1:0]   count_q;
	logic [pst_pkg::CNT_W-1:0]   tick_idx_q;
	logic [pst_pkg::SLOT_W-1:0]  slot_q;
	logic                        hit_q;
	logic                        full_q;
	logic                        fresh_q;
	logic [47:0]                 e_mac_q;
	logic [15:0]                 e_seq_q;
	logic [15:0]                 e_rcv_q;
	logic [15:0]                 e_mis_q;
	logic signed [7:0]           e_raw_q;
	logic signed [15:0]          e_smooth_q;
	logic [31:0]                 e_seen_q;
	logic                        e_online_q;
	logic [15:0]                 mis_q;
	logic signed [17:0]          p1_q;
	logic signed [25:0]          p2_q;
	pst_pkg::out_t               res_q;
	logic                        done_q;

	logic                        any_hit;
	logic [pst_pkg::SLOT_W-1:0]  hit_idx;
	logic [15:0]                 delta;
	logic                        chk;
	logic                        fresh_c;
	logic [16:0]                 mis_sum;
	logic [8:0]                  w_c;
	logic [9:0]                  w_inv;
	logic signed [26:0]          ema_sum;
	logic signed [15:0]          ema_val;
	logic [15:0]                 rcv_inc;
	logic [16:0]                 stat_sum;
	logic                        halve;
	logic signed [15:0]          smooth_new;
	logic [pst_pkg::SLOT_W-1:0]  tick_slot;
	logic [31:0]                 age;

	always_comb begin
		any_hit = 1'b0;
		hit_idx = '0;
		for (int i = pst_pkg::SLOTS - 1; i >= 0; i--) begin
			if ((pst_pkg::CNT_W'(i) < count_q) && (id_mem[i] == job_q.item.peer_id)) begin
				any_hit = 1'b1;
				hit_idx = pst_pkg::SLOT_W'(i);
			end
		end
	end

	always_comb begin
		delta = job_q.item.seq_num - e_seq_q;
		chk = (e_rcv_q != 16'd0);
		fresh_c = !chk || !((delta == 16'd0) || (delta > pst_pkg::STALE_LIMIT));
		mis_sum = {1'b0, e_mis_q} + {1'b0, delta} - 17'd1;
		w_c = (cfg.ema_weight > pst_pkg::WEIGHT_ONE) ? pst_pkg::WEIGHT_ONE : cfg.ema_weight;
		w_inv = 10'd256 - {1'b0, w_c};
		ema_sum = {{1{p1_q[17]}}, p1_q, 8'd0} + {p2_q[25], p2_q} + 27'sd128;
		ema_val = ema_sum[23:8];
		rcv_inc = (e_rcv_q == 16'hFFFF) ? 16'hFFFF : e_rcv_q + 16'd1;
		stat_sum = {1'b0, rcv_inc} + {1'b0, mis_q};
		halve = stat_sum > {1'b0, cfg.stats_limit};
		smooth_new = e_online_q ? ema_val : {job_q.item.rssi_sample, 8'd0};
		tick_slot = tick_idx_q[pst_pkg::SLOT_W-1:0];
		age = job_q.item.now_ms - seen_mem[tick_slot];
	end

	assign pop = (state_q == ST_IDLE) && !empty;
	assign done = done_q;
	assign result = res_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					job_q <= head;
				end
			end
			ST_LOOK: begin
				slot_q <= any_hit ? hit_idx : count_q[pst_pkg::SLOT_W-1:0];
				hit_q <= any_hit;
				full_q <= !any_hit && (count_q == pst_pkg::CNT_W'(pst_pkg::SLOTS));
				if (any_hit) begin
					e_mac_q <= mac_mem[hit_idx];
					e_seq_q <= seq_mem[hit_idx];
					e_rcv_q <= rcv_mem[hit_idx];
					e_mis_q <= mis_mem[hit_idx];
					e_raw_q <= raw_mem[hit_idx];
					e_smooth_q <= smooth_mem[hit_idx];
					e_seen_q <= seen_mem[hit_idx];
					e_online_q <= online_mem[hit_idx];
				end else begin
					e_mac_q <= '0;
					e_seq_q <= '0;
					e_rcv_q <= '0;
					e_mis_q <= '0;
					e_raw_q <= '0;
					e_smooth_q <= '0;
					e_seen_q <= '0;
					e_online_q <= 1'b0;
				end
			end
			ST_CALC: begin
				fresh_q <= fresh_c;
				if (chk && fresh_c) begin
					mis_q <= mis_sum[16] ? 16'hFFFF : mis_sum[15:0];
				end else begin
					mis_q <= e_mis_q;
				end
				p1_q <= 18'($signed({1'b0, w_c})) * 18'(job_q.item.rssi_sample);
				p2_q <= 26'($signed(w_inv)) * 26'(e_smooth_q);
			end
			ST_WRITE: begin
				if (job_q.cls.is_pkt && !full_q && fresh_q) begin
					id_mem[slot_q] <= job_q.item.peer_id;
					mac_mem[slot_q] <= job_q.item.mac_addr;
					seq_mem[slot_q] <= job_q.item.seq_num;
					rcv_mem[slot_q] <= halve ? (rcv_inc >> 1) : rcv_inc;
					mis_mem[slot_q] <= halve ? (mis_q >> 1) : mis_q;
					raw_mem[slot_q] <= job_q.item.rssi_sample;
					smooth_mem[slot_q] <= smooth_new;
					seen_mem[slot_q] <= job_q.item.now_ms;
					online_mem[slot_q] <= 1'b1;
				end
			end
			ST_TICK: begin
				if (tick_idx_q < count_q) begin
					if (online_mem[tick_slot] && (age > cfg.offline_timeout)) begin
						online_mem[tick_slot] <= 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			res_q <= '0;
			if (job_q.cls.is_pkt) begin
				if (full_q) begin
					res_q.table_full <= 1'b1;
				end else if (fresh_q) begin
					res_q.fresh <= 1'b1;
					res_q.found <= 1'b1;
					res_q.is_online <= 1'b1;
					res_q.last_seq_out <= job_q.item.seq_num;
					res_q.received_count <= halve ? (rcv_inc >> 1) : rcv_inc;
					res_q.missed_count <= halve ? (mis_q >> 1) : mis_q;
					res_q.raw_rssi <= job_q.item.rssi_sample;
					res_q.smooth_rssi <= smooth_new;
					res_q.last_seen <= job_q.item.now_ms;
					res_q.peer_mac <= job_q.item.mac_addr;
				end else begin
					res_q.found <= 1'b1;
					res_q.is_online <= e_online_q;
					res_q.last_seq_out <= e_seq_q;
					res_q.received_count <= e_rcv_q;
					res_q.missed_count <= e_mis_q;
					res_q.raw_rssi <= e_raw_q;
					res_q.smooth_rssi <= e_smooth_q;
					res_q.last_seen <= e_seen_q;
					res_q.peer_mac <= e_mac_q;
				end
			end else if (job_q.cls.is_look && hit_q) begin
				res_q.found <= 1'b1;
				res_q.is_online <= e_online_q;
				res_q.last_seq_out <= e_seq_q;
				res_q.received_count <= e_rcv_q;
				res_q.missed_count <= e_mis_q;
				res_q.raw_rssi <= e_raw_q;
				res_q.smooth_rssi <= e_smooth_q;
				res_q.last_seen <= e_seen_q;
				res_q.peer_mac <= e_mac_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			tick_idx_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						tick_idx_q <= '0;
						if (head.cls.is_pkt || head.cls.is_look) begin
							state_q <= ST_LOOK;
						end else if (head.cls.is_tick) begin
							state_q <= ST_TICK;
						end else begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_LOOK: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (job_q.cls.is_pkt && !full_q && fresh_q && !hit_q) begin
						count_q <= count_q + pst_pkg::CNT_W'(1);
					end
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_TICK: begin
					if (tick_idx_q < count_q) begin
						tick_idx_q <= tick_idx_q + pst_pkg::CNT_W'(1);
					end else begin
						state_q <= ST_WRITE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/peer_sequence_tracker.sv]
// A packet or lookup item, once accepted, leaves the two-entry input queue and then passes the
// search, arithmetic and write-back steps of the table engine before its result strobe. A tick
// item walks the table one peer per cycle and then takes the write-back step. The engine serves
// one item at a time; busy rises only when the input queue is full.
// The result is shown for one cycle with done high and must be taken then.
module peer_sequence_tracker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pst_pkg::in_t  cmd,
	output logic          done,
	output pst_pkg::out_t result,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	pst_pkg::cfg_t cfg_q;
	pst_pkg::job_t head;
	logic          empty;
	logic          pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ema_weight <= 9'd64;
			cfg_q.offline_timeout <= 32'd5000;
			cfg_q.stats_limit <= 16'd2000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pst_pkg::CFG_EMA_WEIGHT: cfg_q.ema_weight <= cfg_data[8:0];
				pst_pkg::CFG_TIMEOUT:    cfg_q.offline_timeout <= cfg_data;
				pst_pkg::CFG_STATS_LIM:  cfg_q.stats_limit <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	pst_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.pop    (pop),
		.empty  (empty),
		.head   (head)
	);

	pst_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule

[rtl/core/pst_checker.sv]
module pst_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          done,
	input pst_pkg::out_t result
);

	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done strobe in consecutive cycles");

	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.table_full |-> !result.found && !result.fresh)
		else $error("table full with an entry reported");

	a_fresh_online: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.fresh |-> result.found && result.is_online)
		else $error("fresh item without online entry");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.found |-> result.received_count == 16'd0 && !result.is_online)
		else $error("fields set without an entry");

endmodule

bind peer_sequence_tracker pst_checker u_pst_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.done   (done),
	.result (result)
);

[sim/peer_table_monitor.sv]
module peer_table_monitor
	import pst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  in_t         cmd,
	input  logic        done,
	input  out_t        result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fails,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [8:0]  weight;
	logic [31:0] timeout_ms;
	logic [15:0] limit;

	int          used;
	logic [31:0] peer_ids [SLOTS];
	logic [47:0] macs [SLOTS];
	logic [15:0] seqs [SLOTS];
	int          rx_cnt [SLOTS];
	int          miss_cnt [SLOTS];
	logic signed [7:0]  raw [SLOTS];
	logic signed [15:0] smooth [SLOTS];
	logic [31:0] seen [SLOTS];
	logic        online [SLOTS];

	out_t expected_results [$];

	function automatic int lookup_slot(logic [31:0] id);
		for (int i = 0; i < used; i++)
			if (peer_ids[i] == id)
				return i;
		return -1;
	endfunction

	function automatic out_t entry_view(int s);
		out_t r;
		r = '0;
		r.found = 1'b1;
		r.is_online = online[s];
		r.last_seq_out = seqs[s];
		r.received_count = rx_cnt[s][15:0];
		r.missed_count = miss_cnt[s][15:0];
		r.raw_rssi = raw[s];
		r.smooth_rssi = smooth[s];
		r.last_seen = seen[s];
		r.peer_mac = macs[s];
		return r;
	endfunction

	function automatic logic signed [15:0] blend(int sample, int prev);
		int wi;
		int acc;
		wi = (weight > WEIGHT_ONE) ? 256 : int'(weight);
		acc = wi * sample + (256 - wi) * prev + 128;
		return 16'(acc >>> 8);
	endfunction

	task automatic track_item(in_t c, output out_t r);
		int s;
		logic is_new;
		logic [15:0] delta;
		int m;
		r = '0;
		case (c.mode)
			MODE_PKT: begin
				is_new = 1'b1;
				s = lookup_slot(c.peer_id);
				if (s < 0 && used >= SLOTS) begin
					r.table_full = 1'b1;
					return;
				end
				if (s < 0) begin
					s = used;
					used++;
					peer_ids[s] = c.peer_id;
					macs[s] = '0;
					seqs[s] = '0;
					rx_cnt[s] = 0;
					miss_cnt[s] = 0;
					raw[s] = '0;
					smooth[s] = '0;
					seen[s] = '0;
					online[s] = 1'b0;
				end
				if (rx_cnt[s] > 0) begin
					delta = c.seq_num - seqs[s];
					if (delta == 0 || delta > STALE_LIMIT) begin
						is_new = 1'b0;
					end else begin
						m = miss_cnt[s] + int'(delta) - 1;
						miss_cnt[s] = (m > 65535) ? 65535 : m;
					end
				end
				if (is_new) begin
					macs[s] = c.mac_addr;
					seqs[s] = c.seq_num;
					if (rx_cnt[s] < 65535)
						rx_cnt[s]++;
					raw[s] = c.rssi_sample;
					smooth[s] = online[s] ? blend(int'(c.rssi_sample) * 256, int'(smooth[s]))
						: 16'(int'(c.rssi_sample) * 256);
					seen[s] = c.now_ms;
					online[s] = 1'b1;
					if (rx_cnt[s] + miss_cnt[s] > int'(limit)) begin
						rx_cnt[s] = rx_cnt[s] >> 1;
						miss_cnt[s] = miss_cnt[s] >> 1;
					end
				end
				r = entry_view(s);
				r.fresh = is_new;
			end
			MODE_TICK: begin
				for (int i = 0; i < used; i++)
					if (online[i] && (c.now_ms - seen[i]) > timeout_ms)
						online[i] = 1'b0;
			end
			MODE_LOOK: begin
				s = lookup_slot(c.peer_id);
				if (s >= 0)
					r = entry_view(s);
			end
			default: ;
		endcase
	endtask

	task automatic report(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch at %0t: %s got %0h, expected %0h", $realtime, field, got, want);
		fails++;
	endtask

	task automatic compare_field(string field, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report(field, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t r;
		out_t want;
		if (!arst_n) begin
			weight <= 9'd64;
			timeout_ms <= 32'd5000;
			limit <= 16'd2000;
			used = 0;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_EMA_WEIGHT: weight <= cfg_data[8:0];
					CFG_TIMEOUT:    timeout_ms <= cfg_data;
					CFG_STATS_LIM:  limit <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				track_item(cmd, r);
				expected_results.push_back(r);
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					report("unexpected result", 64'(result.found), 64'd0);
				end else begin
					want = expected_results.pop_front();
					compare_field("fresh", 64'(result.fresh), 64'(want.fresh));
					compare_field("found", 64'(result.found), 64'(want.found));
					compare_field("table_full", 64'(result.table_full), 64'(want.table_full));
					compare_field("is_online", 64'(result.is_online), 64'(want.is_online));
					compare_field("last_seq_out", 64'(result.last_seq_out),
						64'(want.last_seq_out));
					compare_field("received_count", 64'(result.received_count),
						64'(want.received_count));
					compare_field("missed_count", 64'(result.missed_count),
						64'(want.missed_count));
					compare_field("raw_rssi", 64'(unsigned'(result.raw_rssi)),
						64'(unsigned'(want.raw_rssi)));
					compare_field("smooth_rssi", 64'(unsigned'(result.smooth_rssi)),
						64'(unsigned'(want.smooth_rssi)));
					compare_field("last_seen", 64'(result.last_seen), 64'(want.last_seen));
					compare_field("peer_mac", 64'(result.peer_mac), 64'(want.peer_mac));
				end
			end
			pending <= expected_results.size();
		end
	end

	initial fails = 0;

endmodule

[sim/testbench.sv]
module testbench;
	import pst_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_t         cmd;
	logic        done;
	out_t        result;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	int          fails;
	int          pending;

	logic [31:0] pool_ids [12];
	logic [15:0] pool_seq [12];
	logic [31:0] clock_ms;
	logic        calm;

	peer_sequence_tracker DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	peer_table_monitor monitor (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .fails(fails), .pending(pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#2ms;
		$display("testbench: done, errors");
		$finish;
	end

	task automatic issue(in_t c);
		while (!calm && $urandom_range(99) < 28) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic packet(int p, logic [15:0] seq, logic signed [7:0] rssi);
		in_t c;
		c.mode = MODE_PKT;
		c.peer_id = pool_ids[p];
		c.mac_addr = 48'({$urandom, $urandom});
		c.seq_num = seq;
		c.rssi_sample = rssi;
		c.now_ms = clock_ms;
		issue(c);
	endtask

	task automatic simple(logic [1:0] mode, logic [31:0] id);
		in_t c;
		c.mode = mode;
		c.peer_id = id;
		c.mac_addr = 48'({$urandom, $urandom});
		c.seq_num = 16'($urandom);
		c.rssi_sample = 8'($urandom);
		c.now_ms = clock_ms;
		issue(c);
	endtask

	task automatic configure(logic [8:0] w, logic [31:0] t, logic [15:0] l);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_EMA_WEIGHT;
		cfg_data <= 32'(w);
		@(posedge clk);
		cfg_index <= CFG_TIMEOUT;
		cfg_data <= t;
		@(posedge clk);
		cfg_index <= CFG_STATS_LIM;
		cfg_data <= 32'(l);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_item();
		int p;
		int pick;
		int g;
		clock_ms = ($urandom_range(99) < 2) ? $urandom : clock_ms + $urandom_range(0, 400);
		pick = $urandom_range(99);
		p = $urandom_range(11);
		if (pick < 60) begin
			g = $urandom_range(99);
			if (g < 70)
				pool_seq[p] = pool_seq[p] + 16'd1;
			else if (g < 82)
				pool_seq[p] = pool_seq[p] + 16'($urandom_range(2, 40));
			else if (g < 86)
				pool_seq[p] = pool_seq[p] + 16'($urandom_range(0, 1) ? 16'h8000 : 16'h8001);
			else if (g < 92)
				pool_seq[p] = pool_seq[p] - 16'($urandom_range(1, 50));
			else if (g < 96)
				pool_seq[p] = 16'($urandom);
			packet(p, pool_seq[p], 8'($urandom));
		end else if (pick < 72) begin
			simple(MODE_TICK, $urandom);
		end else if (pick < 92) begin
			simple(MODE_LOOK, ($urandom_range(3) == 0) ? $urandom : pool_ids[p]);
		end else begin
			simple(MODE_RSVD, pool_ids[p]);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_EMA_WEIGHT;
		cfg_data = '0;
		calm = 1'b0;
		foreach (pool_ids[i]) begin
			pool_ids[i] = $urandom;
			pool_seq[i] = 16'($urandom);
		end
		pool_ids[1] = 32'hFFFF_FFFF;
		pool_ids[2] = 32'h0;
		clock_ms = 32'hFFFF_FFF0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		packet(0, 16'hFFFF, -8'sd128);
		packet(0, 16'hFFFF, 8'sd0);
		clock_ms = clock_ms + 32'd40;
		packet(0, 16'h0000, 8'sd127);
		packet(0, 16'hFFF0, 8'sd5);
		packet(0, 16'h8000, -8'sd60);
		simple(MODE_LOOK, pool_ids[0]);
		simple(MODE_LOOK, 32'h1234_5678);
		clock_ms = clock_ms + 32'd6000;
		simple(MODE_TICK, 32'h0);
		simple(MODE_LOOK, pool_ids[0]);
		packet(0, 16'h8001, -8'sd20);
		simple(MODE_RSVD, pool_ids[0]);
		for (int i = 1; i < 9; i++)
			packet(i, pool_seq[i], 8'($urandom));
		simple(MODE_LOOK, pool_ids[8]);

		configure(9'd256, 32'd0, 16'd1);
		packet(1, pool_seq[1] + 16'd1, 8'sd10);
		packet(1, pool_seq[1] + 16'd2, 8'sd11);
		simple(MODE_TICK, 32'h0);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: configure(9'd0, 32'd0, 16'd1);
				1: configure(9'd511, 32'hFFFF_FFFF, 16'd65535);
				2: configure(9'd256, 32'd300, 16'd3);
				default: configure(9'($urandom_range(0, 511)), $urandom_range(0, 3000),
					16'($urandom_range(1, 3) == 1 ? $urandom_range(1, 65535)
						: $urandom_range(1, 60)));
			endcase
			calm = (ph == 2);
			for (int n = 0; n < 145; n++)
				random_item();
		end
		calm = 1'b0;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (fails == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

[sim.f]
rtl/core/pst_pkg.sv
rtl/core/pst_front.sv
rtl/core/pst_back.sv
rtl/core/peer_sequence_tracker.sv
rtl/core/pst_checker.sv
sim/peer_table_monitor.sv
sim/testbench.sv
